### rtl/core/thca_pkg.sv
package thca_pkg;

	// field widths
	localparam int RAW_W       = 16;
	localparam int OPCODE_W    = 2;
	localparam int BYTE_W      = 8;
	localparam int LEVEL_W     = 7;
	localparam int CFG_INDEX_W = 2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_TEMP  = 2'd0,
		OP_HUM   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TEMP_ALARM = 2'd0,
		REG_TEMP_TRIP  = 2'd1,
		REG_RH_ALARM   = 2'd2,
		REG_RH_TRIP    = 2'd3
	} reg_index_t;

	// level registers
	localparam logic [LEVEL_W-1:0] LEVEL_MAX            = 7'd100;
	localparam logic [LEVEL_W-1:0] TEMP_ALARM_LEVEL_RST = 7'd60;
	localparam logic [LEVEL_W-1:0] TEMP_TRIP_LEVEL_RST  = 7'd70;
	localparam logic [LEVEL_W-1:0] RH_ALARM_LEVEL_RST   = 7'd80;
	localparam logic [LEVEL_W-1:0] RH_TRIP_LEVEL_RST    = 7'd90;

	// temperature: raw >> 7, minus offset, modulo 256
	localparam int                TEMP_SHIFT  = 7;
	localparam logic [BYTE_W-1:0] TEMP_OFFSET = 8'd50;

	// humidity fixed point, 16 fraction bits
	localparam int FRAC_W      = 16;
	localparam int CURVE_W     = 13;   // raw >> 4 minus 24*16, signed
	localparam int CURVE_SHIFT = 12;   // curve in Q16 is c * 4096
	localparam int RAW_SHIFT   = 4;
	localparam int SQ_W        = 24;   // c*c
	localparam int A2_SHIFT    = 7;    // c*c*258/256 = c*c + (c*c >> 7)
	localparam int A1_SHIFT    = 4;    // c*4096*a1/65536 = c*a1/16
	localparam int LIN_W       = 27;
	localparam int COMP_W      = 19;
	localparam int SUM_W       = 28;
	localparam int TDIFF_W     = 9;

	localparam logic signed [CURVE_W-1:0] CURVE_OFFSET = 13'sd384;
	localparam logic signed [LIN_W-1:0]   A0_NEG       = 27'sd313550;
	localparam logic signed [COMP_W-1:0]  Q0_COEF      = 19'sd12930;
	localparam logic signed [TDIFF_W-1:0] TEMP_REF     = 9'sd30;

	// shared radix-4 multiplier
	localparam int MUL_A_W    = 26;
	localparam int MUL_B_W    = 12;
	localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
	localparam int DIGIT_W    = 2;
	localparam int MUL_DIGITS = MUL_B_W / DIGIT_W;

	localparam logic [MUL_A_W-1:0] A1_COEF = 26'd26267;
	localparam logic [MUL_B_W-1:0] Q1_COEF = 12'd155;

	typedef enum logic [2:0] {
		E_IDLE,
		E_SQ,
		E_A1,
		E_LIN,
		E_Q1,
		E_CMP,
		E_HUM,
		E_DONE
	} eng_state_t;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               done;
		logic [MUL_P_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic              start;
		logic              ack;
		logic [RAW_W-1:0]  raw;
		logic [BYTE_W-1:0] last_temp;
	} hum_req_t;

	typedef struct packed {
		logic              done;
		logic [BYTE_W-1:0] humidity;
	} hum_rsp_t;

	typedef struct packed {
		logic temp_alarm;
		logic temp_trip;
		logic rh_alarm;
		logic rh_trip;
	} flags_t;

	typedef struct packed {
		logic [BYTE_W-1:0] temperature;
		logic [BYTE_W-1:0] humidity;
		flags_t            flags;
	} report_t;

endpackage

### rtl/core/thca_sample_if.sv
interface thca_sample_if;
	import thca_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [RAW_W-1:0]    raw_word;

	modport source (output valid, output opcode, output raw_word, input ready);
	modport sink (input valid, input opcode, input raw_word, output ready);

endinterface

### rtl/core/thca_report_if.sv
interface thca_report_if;
	import thca_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] temperature;
	logic [BYTE_W-1:0] humidity;
	logic              temp_alarm;
	logic              temp_trip;
	logic              rh_alarm;
	logic              rh_trip;

	modport source (
		output valid, output temperature, output humidity,
		output temp_alarm, output temp_trip, output rh_alarm, output rh_trip,
		input ready
	);
	modport sink (
		input valid, input temperature, input humidity,
		input temp_alarm, input temp_trip, input rh_alarm, input rh_trip,
		output ready
	);

endinterface

### rtl/core/thca_mul.sv
module thca_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  thca_pkg::mul_req_t req,
	output thca_pkg::mul_rsp_t rsp
);
	import thca_pkg::*;

	localparam int CNT_W = $clog2(MUL_DIGITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_DIGITS - 1);

	logic               prep_q;
	logic               run_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [MUL_P_W-1:0] a_sh_q;
	logic [MUL_P_W-1:0] a3_sh_q;
	logic [MUL_B_W-1:0] b_sh_q;
	logic [MUL_P_W-1:0] acc_q;
	logic [MUL_P_W-1:0] digit_term;

	// partial product for the current radix-4 digit
	always_comb begin
		case (b_sh_q[DIGIT_W-1:0])
			2'd0:    digit_term = '0;
			2'd1:    digit_term = a_sh_q;
			2'd2:    digit_term = a_sh_q << 1;
			default: digit_term = a3_sh_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_q <= 1'b0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				prep_q <= 1'b1;
				run_q  <= 1'b0;
			end else if (prep_q) begin
				prep_q <= 1'b0;
				run_q  <= 1'b1;
				cnt_q  <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_sh_q <= MUL_P_W'(req.a);
			b_sh_q <= req.b;
		end else if (prep_q) begin
			a3_sh_q <= a_sh_q + (a_sh_q << 1);
			acc_q   <= '0;
		end else if (run_q) begin
			acc_q   <= acc_q + digit_term;
			a_sh_q  <= a_sh_q << DIGIT_W;
			a3_sh_q <= a3_sh_q << DIGIT_W;
			b_sh_q  <= b_sh_q >> DIGIT_W;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

### rtl/core/thca_hum.sv
module thca_hum (
	input  logic               clk,
	input  logic               arst_n,
	input  thca_pkg::hum_req_t req,
	output thca_pkg::hum_rsp_t rsp,
	output thca_pkg::mul_req_t mreq,
	input  thca_pkg::mul_rsp_t mrsp
);
	import thca_pkg::*;

	eng_state_t state_q;
	eng_state_t state_nxt;

	logic                     cneg_q;
	logic [MUL_B_W-1:0]       cmag_q;
	logic                     tneg_q;
	logic [BYTE_W-1:0]        tmag_q;
	logic signed [LIN_W-1:0]  lin_q;
	logic signed [COMP_W-1:0] comp_q;
	logic [BYTE_W-1:0]        hum_q;

	logic signed [CURVE_W-1:0] c_in;
	logic [CURVE_W-1:0]        c_abs;
	logic signed [TDIFF_W-1:0] t_in;
	logic [TDIFF_W-1:0]        t_abs;
	logic signed [LIN_W-1:0]   lin_init;
	logic [SQ_W-1:0]           sq;
	logic [SQ_W:0]             term2;
	logic [LIN_W-1:0]          s1;
	logic [LIN_W-1:0]          lin_abs;
	logic signed [COMP_W-1:0]  comp_mag;
	logic [COMP_W-1:0]         comp_abs;
	logic [SUM_W-1:0]          p3;
	logic signed [SUM_W-1:0]   tc;
	logic signed [SUM_W-1:0]   sum;
	logic [SUM_W-FRAC_W-1:0]   hq;
	logic [BYTE_W-1:0]         hum_sat;

	// operand preparation and result shaping
	always_comb begin
		c_in     = $signed({1'b0, req.raw[RAW_W-1:RAW_SHIFT]}) - CURVE_OFFSET;
		c_abs    = c_in[CURVE_W-1] ? CURVE_W'(-c_in) : CURVE_W'(c_in);
		t_in     = $signed({1'b0, req.last_temp}) - TEMP_REF;
		t_abs    = t_in[TDIFF_W-1] ? TDIFF_W'(-t_in) : TDIFF_W'(t_in);
		lin_init = (LIN_W'(c_in) <<< CURVE_SHIFT) + A0_NEG;
		sq       = mrsp.prod[SQ_W-1:0];
		term2    = {1'b0, sq} + (SQ_W + 1)'(sq >> A2_SHIFT);
		s1       = LIN_W'(mrsp.prod >> A1_SHIFT);
		lin_abs  = lin_q[LIN_W-1] ? LIN_W'(-lin_q) : LIN_W'(lin_q);
		comp_mag = $signed(COMP_W'(mrsp.prod >> FRAC_W));
		comp_abs = comp_q[COMP_W-1] ? COMP_W'(-comp_q) : COMP_W'(comp_q);
		p3       = SUM_W'(mrsp.prod);
		tc       = (comp_q[COMP_W-1] ^ tneg_q) ? -$signed(p3) : $signed(p3);
		sum      = SUM_W'(lin_q) + tc;
		hq       = sum[SUM_W-1:FRAC_W];
		// negative truncates to zero or below, so it saturates to zero
		if (sum[SUM_W-1]) begin
			hum_sat = '0;
		end else if (|hq[SUM_W-FRAC_W-1:BYTE_W]) begin
			hum_sat = '1;
		end else begin
			hum_sat = hq[BYTE_W-1:0];
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			E_IDLE: if (req.start) state_nxt = E_SQ;
			E_SQ:   if (mrsp.done) state_nxt = E_A1;
			E_A1:   if (mrsp.done) state_nxt = E_LIN;
			E_LIN:  state_nxt = E_Q1;
			E_Q1:   if (mrsp.done) state_nxt = E_CMP;
			E_CMP:  state_nxt = E_HUM;
			E_HUM:  if (mrsp.done) state_nxt = E_DONE;
			E_DONE: if (req.ack) state_nxt = E_IDLE;
			default: state_nxt = E_IDLE;
		endcase
	end

	always_comb begin
		mreq.start = 1'b0;
		mreq.a     = '0;
		mreq.b     = '0;
		case (state_q)
			E_IDLE: begin
				mreq.start = req.start;
				mreq.a     = MUL_A_W'(c_abs[MUL_B_W-1:0]);
				mreq.b     = c_abs[MUL_B_W-1:0];
			end
			E_SQ: begin
				mreq.start = mrsp.done;
				mreq.a     = A1_COEF;
				mreq.b     = cmag_q;
			end
			E_LIN: begin
				mreq.start = 1'b1;
				mreq.a     = lin_abs[MUL_A_W-1:0];
				mreq.b     = Q1_COEF;
			end
			E_CMP: begin
				mreq.start = 1'b1;
				mreq.a     = MUL_A_W'(comp_abs);
				mreq.b     = MUL_B_W'(tmag_q);
			end
			default: begin
				mreq.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			E_IDLE: if (req.start) begin
				cneg_q <= c_in[CURVE_W-1];
				cmag_q <= c_abs[MUL_B_W-1:0];
				tneg_q <= t_in[TDIFF_W-1];
				tmag_q <= t_abs[BYTE_W-1:0];
				lin_q  <= lin_init;
			end
			E_SQ: if (mrsp.done) begin
				lin_q <= lin_q + $signed(LIN_W'(term2));
			end
			E_A1: if (mrsp.done) begin
				lin_q <= cneg_q ? lin_q + $signed(s1) : lin_q - $signed(s1);
			end
			E_Q1: if (mrsp.done) begin
				comp_q <= (lin_q[LIN_W-1] ? -comp_mag : comp_mag) + Q0_COEF;
			end
			E_HUM: if (mrsp.done) begin
				hum_q <= hum_sat;
			end
			default: begin
			end
		endcase
	end

	assign rsp.done     = (state_q == E_DONE);
	assign rsp.humidity = hum_q;

endmodule

### rtl/core/temp_humidity_convert_alarm.sv
// channel   dir  modport        payload                                   transaction
// sample    in   sample.sink    opcode[1:0], raw_word[15:0]               valid & ready
// report    out  report.source  temperature[7:0], humidity[7:0], 4 flags  valid & ready
// cfg       in   write only     cfg_index[1:0], cfg_data[6:0]             cfg_write_en
//
// one transaction is worked at a time; temperature, clear and no-op commit without the
// multiplier, a humidity sample first runs four products in turn through the shared
// radix-4 shift-add multiplier
// the report register parts the two sides: a new sample is taken while a result waits
// arst_n clears stored values, flags and handshake state; levels return to 60/70/80/90
// a stalled report holds the finished sample, which then waits to commit
module temp_humidity_convert_alarm (
	input  logic                             clk,
	input  logic                             arst_n,
	thca_sample_if.sink                      sample,
	thca_report_if.source                    report,
	input  logic                             cfg_write_en,
	input  logic [thca_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [thca_pkg::LEVEL_W-1:0]     cfg_data
);
	import thca_pkg::*;

	// level registers
	logic [LEVEL_W-1:0] temp_alarm_level_q;
	logic [LEVEL_W-1:0] temp_trip_level_q;
	logic [LEVEL_W-1:0] rh_alarm_level_q;
	logic [LEVEL_W-1:0] rh_trip_level_q;
	logic [LEVEL_W-1:0] cfg_clamped;

	// transaction in flight
	logic              busy_q;
	opcode_t           op_q;
	logic [RAW_W-1:0]  raw_q;

	// stored state
	logic [BYTE_W-1:0] temp_q;
	logic [BYTE_W-1:0] hum_q;
	flags_t            flags_q;

	// report register
	logic              out_valid_q;
	report_t           out_q;

	// next state at commit
	logic [BYTE_W-1:0] temp_conv;
	logic [BYTE_W-1:0] temp_nxt;
	logic [BYTE_W-1:0] hum_nxt;
	flags_t            flags_nxt;
	logic              commit;

	hum_req_t hreq;
	hum_rsp_t hrsp;
	mul_req_t mreq;
	mul_rsp_t mrsp;

	// config writes clamp to the top of the level range
	assign cfg_clamped = (cfg_data > LEVEL_MAX) ? LEVEL_MAX : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_alarm_level_q <= TEMP_ALARM_LEVEL_RST;
			temp_trip_level_q  <= TEMP_TRIP_LEVEL_RST;
			rh_alarm_level_q   <= RH_ALARM_LEVEL_RST;
			rh_trip_level_q    <= RH_TRIP_LEVEL_RST;
		end else if (cfg_write_en) begin
			case (reg_index_t'(cfg_index))
				REG_TEMP_ALARM: temp_alarm_level_q <= cfg_clamped;
				REG_TEMP_TRIP:  temp_trip_level_q  <= cfg_clamped;
				REG_RH_ALARM:   rh_alarm_level_q   <= cfg_clamped;
				REG_RH_TRIP:    rh_trip_level_q    <= cfg_clamped;
				default: begin
				end
			endcase
		end
	end

	// humidity engine and its multiplier
	assign hreq.start     = busy_q && (op_q == OP_HUM);
	assign hreq.ack       = commit;
	assign hreq.raw       = raw_q;
	assign hreq.last_temp = temp_q;

	thca_hum u_hum (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.rsp    (hrsp),
		.mreq   (mreq),
		.mrsp   (mrsp)
	);

	thca_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	// commit once the result is ready and the report register is free
	assign commit = busy_q && ((op_q != OP_HUM) || hrsp.done)
		&& (!out_valid_q || report.ready);

	// temperature wraps modulo 256
	assign temp_conv = raw_q[TEMP_SHIFT +: BYTE_W] - TEMP_OFFSET;

	always_comb begin
		temp_nxt  = temp_q;
		hum_nxt   = hum_q;
		flags_nxt = flags_q;
		case (op_q)
			OP_TEMP: begin
				temp_nxt = temp_conv;
				if (temp_conv > BYTE_W'(temp_alarm_level_q)) flags_nxt.temp_alarm = 1'b1;
				if (temp_conv > BYTE_W'(temp_trip_level_q))  flags_nxt.temp_trip  = 1'b1;
			end
			OP_HUM: begin
				hum_nxt = hrsp.humidity;
				if (hrsp.humidity > BYTE_W'(rh_alarm_level_q)) flags_nxt.rh_alarm = 1'b1;
				if (hrsp.humidity > BYTE_W'(rh_trip_level_q))  flags_nxt.rh_trip  = 1'b1;
			end
			OP_CLEAR: begin
				flags_nxt = '0;
			end
			default: begin
				// unused opcode reports the state unchanged
			end
		endcase
	end

	assign sample.ready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			op_q        <= OP_NONE;
			temp_q      <= '0;
			hum_q       <= '0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (sample.valid && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= opcode_t'(sample.opcode);
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				temp_q      <= temp_nxt;
				hum_q       <= hum_nxt;
				flags_q     <= flags_nxt;
				out_valid_q <= 1'b1;
			end else if (report.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && !busy_q) begin
			raw_q <= sample.raw_word;
		end
		if (commit) begin
			out_q.temperature <= temp_nxt;
			out_q.humidity    <= hum_nxt;
			out_q.flags       <= flags_nxt;
		end
	end

	assign report.valid       = out_valid_q;
	assign report.temperature = out_q.temperature;
	assign report.humidity    = out_q.humidity;
	assign report.temp_alarm  = out_q.flags.temp_alarm;
	assign report.temp_trip   = out_q.flags.temp_trip;
	assign report.rh_alarm    = out_q.flags.rh_alarm;
	assign report.rh_trip     = out_q.flags.rh_trip;

endmodule

### rtl/core/thca_check.sv
module thca_check (
	input  logic          clk,
	input  logic          arst_n,
	thca_sample_if.sink   sample,
	thca_report_if.source report
);

	logic       in_fire;
	logic       out_fire;
	logic [1:0] pending_q;

	assign in_fire  = sample.valid && sample.ready;
	assign out_fire = report.valid && report.ready;

	// samples taken but not yet reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_fire && !out_fire) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_fire && !in_fire) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// one transaction in flight: no sample right after one is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !sample.ready)
		else $error("sample taken while a transaction is in flight");

	// at most one in work plus one waiting in the report register
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two transactions outstanding");

	// every report comes from an accepted sample
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		report.valid |-> pending_q != 2'd0)
		else $error("report without a matching sample");

	a_report_hold: assert property (@(posedge clk) disable iff (!arst_n)
		report.valid && !report.ready |=> report.valid
			&& $stable(report.temperature) && $stable(report.humidity))
		else $error("stalled report changed");

endmodule

bind temp_humidity_convert_alarm thca_check u_thca_check (
	.clk    (clk),
	.arst_n (arst_n),
	.sample (sample),
	.report (report)
);
